// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the clip-reject RTL.
// Define ASSERT_OFF to compile every assertion out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("property failed");

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- design/lscr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscr_pkg
// Widths, codes and interface types of the line segment clip-reject block.
// ----------------------------------------------------------------------------
package lscr_pkg;

	// Fixed-point format and pass limit
	localparam int FRAC_BITS  = 16;
	localparam int MAX_PASSES = 8;

	// Datapath widths
	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int MAG_W   = COORD_W;
	localparam int PROD_W  = 2 * MAG_W;
	localparam int QCLAMP  = 40;
	localparam int QUOT_W  = QCLAMP + 1;
	localparam int SUM_W   = QCLAMP + 2;
	localparam int PASS_W  = $clog2(MAX_PASSES + 1);
	localparam int STEP_W  = $clog2(PROD_W);
	localparam int ADDR_W  = 4;
	localparam int CODE_W  = 4;

	// Window reset values: plus and minus one
	localparam logic signed [COORD_W-1:0] WIN_ONE       = COORD_W'(1 << FRAC_BITS);
	localparam logic signed [COORD_W-1:0] WIN_MINUS_ONE = -WIN_ONE;

	// Outcode bit positions
	localparam int BIT_LEFT   = 0;
	localparam int BIT_RIGHT  = 1;
	localparam int BIT_BOTTOM = 2;
	localparam int BIT_TOP    = 3;

	// Register indexes
	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_RIGHT  = 2'd1;
	localparam logic [1:0] REG_BOTTOM = 2'd2;
	localparam logic [1:0] REG_TOP    = 2'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] top;
	} window_t;

	// Request to the shared multiply/divide unit
	typedef struct packed {
		logic                     go;
		logic signed [DIFF_W-1:0] span;
		logic signed [DIFF_W-1:0] num;
		logic signed [DIFF_W-1:0] den;
	} md_req_t;

	// Clamped quotient magnitude, valid while done is high
	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} md_rsp_t;

endpackage

// ----- design/lscr_muldiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscr_muldiv
// Shared unit: registers |span| * |num|, then a restoring divide by |den|,
// one quotient bit per cycle. The quotient is clamped to 2^40.
// ----------------------------------------------------------------------------
module lscr_muldiv import lscr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	localparam logic [1:0] MD_IDLE = 2'd0;
	localparam logic [1:0] MD_MUL  = 2'd1;
	localparam logic [1:0] MD_DIV  = 2'd2;
	localparam logic [1:0] MD_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [MAG_W-1:0]  mag_a_q;
	logic [MAG_W-1:0]  mag_b_q;
	logic [MAG_W-1:0]  mag_d_q;
	logic [PROD_W-1:0] pq_q;
	logic [MAG_W-1:0]  rem_q;
	logic [PROD_W-1:0] prod;
	logic [MAG_W:0]    rem_sh;
	logic [MAG_W:0]    rem_sub;
	logic              rem_ge;

	function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
		logic signed [DIFF_W-1:0] n;
		n = v[DIFF_W-1] ? -v : v;
		return n[MAG_W-1:0];
	endfunction

	// Multiply and one divide step
	assign prod    = PROD_W'(mag_a_q) * PROD_W'(mag_b_q);
	assign rem_sh  = {rem_q, pq_q[PROD_W-1]};
	assign rem_sub = rem_sh - {1'b0, mag_d_q};
	assign rem_ge  = rem_sh >= {1'b0, mag_d_q};

	// Clamp the quotient to 2^40
	assign rsp.done = (state_q == MD_DONE);
	assign rsp.quot = (|pq_q[PROD_W-1:QCLAMP]) ? {1'b1, {QCLAMP{1'b0}}}
	                                           : {1'b0, pq_q[QCLAMP-1:0]};

	// Sequence the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				MD_IDLE: begin
					if (req.go) state_q <= MD_MUL;
				end
				MD_MUL: begin
					step_q  <= '0;
					state_q <= (mag_d_q == '0) ? MD_DONE : MD_DIV;
				end
				MD_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(PROD_W - 1)) state_q <= MD_DONE;
				end
				MD_DONE: begin
					state_q <= MD_IDLE;
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	// Operands, product and divide shift register
	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (req.go) begin
					mag_a_q <= mag(req.span);
					mag_b_q <= mag(req.num);
					mag_d_q <= mag(req.den);
				end
			end
			MD_MUL: begin
				// zero divisor gives a zero quotient
				rem_q <= '0;
				pq_q  <= (mag_d_q == '0) ? '0 : prod;
			end
			MD_DIV: begin
				rem_q <= rem_ge ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
				pq_q  <= {pq_q[PROD_W-2:0], rem_ge};
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- design/lscr_clip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscr_clip
// Clip sequencer: holds both endpoints, forms outcodes, decides accept or
// reject, and moves the outside endpoint onto a window edge per pass.
// ----------------------------------------------------------------------------
module lscr_clip import lscr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  window_t                   win,
	input  md_rsp_t                   md_rsp,
	output md_req_t                   md_req,
	output logic                      busy,
	output logic                      done,
	output logic                      rejected
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_SETUP = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	logic [1:0]                state_q;
	logic [PASS_W-1:0]         pass_q;
	logic                      go_q;
	logic                      done_q;
	logic                      rejected_q;
	logic signed [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [DIFF_W-1:0]  span_q, num_q, den_q;
	logic signed [COORD_W-1:0] base_q;
	logic signed [COORD_W-1:0] edge_val_q;
	logic                      by_y_q;
	logic                      side0_q;
	logic                      neg_q;

	logic [CODE_W-1:0]         c0, c1, co;
	logic                      visible, share, by_y;
	logic signed [COORD_W-1:0] edge_val, a0, a1, b0, b1;
	logic signed [DIFF_W-1:0]  span_d, num_d, den_d;
	logic signed [SUM_W-1:0]   base_x, quot_x, sum;
	logic signed [COORD_W-1:0] new_coord;

	function automatic logic [CODE_W-1:0] region(input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y, input window_t w);
		logic [CODE_W-1:0] c;
		c = '0;
		c[BIT_TOP]    = y > w.top;
		c[BIT_BOTTOM] = y < w.bottom;
		c[BIT_RIGHT]  = x > w.right;
		c[BIT_LEFT]   = x < w.left;
		return c;
	endfunction

	function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_W-1:0] v);
		return {v[COORD_W-1], v};
	endfunction

	// Outcodes and the trivial tests
	assign c0      = region(x0_q, y0_q, win);
	assign c1      = region(x1_q, y1_q, win);
	assign visible = (c0 | c1) == '0;
	assign share   = (c0 & c1) != '0;
	assign co      = (c0 != '0) ? c0 : c1;
	assign by_y    = co[BIT_TOP] | co[BIT_BOTTOM];

	// Pick the edge: top, bottom, right, then left
	always_comb begin
		if (co[BIT_TOP])         edge_val = win.top;
		else if (co[BIT_BOTTOM]) edge_val = win.bottom;
		else if (co[BIT_RIGHT])  edge_val = win.right;
		else                     edge_val = win.left;
	end

	// Axis a is the one that crosses the edge, axis b is interpolated
	assign a0 = by_y ? y0_q : x0_q;
	assign a1 = by_y ? y1_q : x1_q;
	assign b0 = by_y ? x0_q : y0_q;
	assign b1 = by_y ? x1_q : y1_q;

	assign span_d = sx(b1) - sx(b0);
	assign num_d  = sx(edge_val) - sx(a0);
	assign den_d  = sx(a1) - sx(a0);

	// Apply the signed quotient and saturate to the coordinate range
	assign base_x = {{(SUM_W-COORD_W){base_q[COORD_W-1]}}, base_q};
	assign quot_x = {1'b0, md_rsp.quot};
	assign sum    = neg_q ? base_x - quot_x : base_x + quot_x;

	always_comb begin
		if ((&sum[SUM_W-1:COORD_W-1]) || !(|sum[SUM_W-1:COORD_W-1])) begin
			new_coord = sum[COORD_W-1:0];
		end else if (sum[SUM_W-1]) begin
			new_coord = COORD_MIN;
		end else begin
			new_coord = COORD_MAX;
		end
	end

	assign md_req.go   = go_q;
	assign md_req.span = span_q;
	assign md_req.num  = num_q;
	assign md_req.den  = den_q;
	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign rejected    = rejected_q;

	// Sequence the passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= '0;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pass_q  <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (visible || share || pass_q == PASS_W'(MAX_PASSES)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					go_q    <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (md_rsp.done) begin
						pass_q  <= pass_q + 1'b1;
						state_q <= ST_CHECK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Endpoints and per-pass operands
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x0_q <= start_x;
					y0_q <= start_y;
					x1_q <= end_x;
					y1_q <= end_y;
				end
			end
			ST_CHECK: begin
				// visible means accepted, anything else that ends here is a reject
				rejected_q <= !visible;
			end
			ST_SETUP: begin
				span_q     <= span_d;
				num_q      <= num_d;
				den_q      <= den_d;
				base_q     <= b0;
				edge_val_q <= edge_val;
				by_y_q     <= by_y;
				side0_q    <= (c0 != '0);
				neg_q      <= span_d[DIFF_W-1] ^ num_d[DIFF_W-1] ^ den_d[DIFF_W-1];
			end
			ST_WAIT: begin
				if (md_rsp.done) begin
					if (side0_q) begin
						if (by_y_q) begin
							x0_q <= new_coord;
							y0_q <= edge_val_q;
						end else begin
							y0_q <= new_coord;
							x0_q <= edge_val_q;
						end
					end else begin
						if (by_y_q) begin
							x1_q <= new_coord;
							y1_q <= edge_val_q;
						end else begin
							y1_q <= new_coord;
							x1_q <= edge_val_q;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- design/line_segment_clip_reject.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_segment_clip_reject
// Sequencing: after the accepting edge the block makes P clip passes, P from
// 0 to 8, then strobes done; each pass runs the 64-step restoring divide in
// the shared multiply/divide unit, skipped when the divisor is zero.
// Throughput: one segment at a time; start is taken in the strobe cycle.
// Reset: arst_n clears the sequencers and sets the window to plus/minus 1.0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_segment_clip_reject import lscr_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [COORD_W-1:0]        pwdata,
	output logic [COORD_W-1:0]        prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	output logic                      done,
	output logic                      rejected
);

	window_t    win_q;
	md_req_t    md_req;
	md_rsp_t    md_rsp;
	logic       cfg_wr;
	logic       accept;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign accept  = start & ~busy;

	// Write the window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.left   <= WIN_MINUS_ONE;
			win_q.right  <= WIN_ONE;
			win_q.bottom <= WIN_MINUS_ONE;
			win_q.top    <= WIN_ONE;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LEFT:   win_q.left   <= pwdata;
				REG_RIGHT:  win_q.right  <= pwdata;
				REG_BOTTOM: win_q.bottom <= pwdata;
				REG_TOP:    win_q.top    <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// Read back the window registers
	always_comb begin
		case (reg_idx)
			REG_LEFT:   prdata = win_q.left;
			REG_RIGHT:  prdata = win_q.right;
			REG_BOTTOM: prdata = win_q.bottom;
			REG_TOP:    prdata = win_q.top;
			default:    prdata = '0;
		endcase
	end

	lscr_clip u_clip (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.start_x  (start_x),
		.start_y  (start_y),
		.end_x    (end_x),
		.end_y    (end_y),
		.win      (win_q),
		.md_rsp   (md_rsp),
		.md_req   (md_req),
		.busy     (busy),
		.done     (done),
		.rejected (rejected)
	);

	lscr_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// Check sequencing between the clip control and the shared unit
	`ASSERT_PROP(a_done_single, clk, arst_n, done |=> !done)
	`ASSERT_PROP(a_accept_busy, clk, arst_n, (start && !busy) |=> busy)
	`ASSERT_PROP(a_done_after_work, clk, arst_n, done |-> $past(busy))
	`ASSERT_PROP(a_md_done_busy, clk, arst_n, md_rsp.done |-> busy)
	`ASSERT_NEVER(a_go_not_done, clk, arst_n, md_req.go && md_rsp.done)

endmodule

// ----- tb/sv/line_segment_clip_reject_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_segment_clip_reject_test
// Self-checking bench for the segment clip-reject block. A local predictor
// runs the outcode clip loop with exact wide arithmetic, and its verdicts are
// compared in order with each done strobe. The run steps through several
// window settings over the APB port and several sender idle levels.
// ----------------------------------------------------------------------------
module line_segment_clip_reject_test;
	import lscr_pkg::*;

	localparam int           Q          = 1 << FRAC_BITS;
	localparam longint       SAT_HI     = 64'sd2147483647;
	localparam longint       SAT_LO     = -64'sd2147483648;
	localparam int           DRAIN_WAIT = 2 + 69 * MAX_PASSES + 40;
	localparam int           PHASES     = 7;
	localparam int           PER_PHASE  = 93;
	localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] ey;
	} segment_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [ADDR_W-1:0]         paddr = '0;
	logic [COORD_W-1:0]        pwdata = '0;
	logic [COORD_W-1:0]        prdata;
	logic                      pready;
	logic                      start = 1'b0;
	logic                      busy;
	logic signed [COORD_W-1:0] start_x = '0;
	logic signed [COORD_W-1:0] start_y = '0;
	logic signed [COORD_W-1:0] end_x = '0;
	logic signed [COORD_W-1:0] end_y = '0;
	logic                      done;
	logic                      rejected;

	// Window as the block should hold it
	longint win_left = -Q;
	longint win_right = Q;
	longint win_bottom = -Q;
	longint win_top = Q;

	segment_t pending_segments[$];
	logic     expected_rejections[$];
	segment_t next_seg;
	int       idle_pct = 0;
	int       items_accepted = 0;
	int       verdicts_checked = 0;
	int       rejects_seen = 0;
	int       mismatches = 0;

	line_segment_clip_reject dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.done(done), .rejected(rejected)
	);

	always #5 clk = ~clk;

	// Clamp to the signed coordinate range
	function automatic logic signed [COORD_W-1:0] sat32(longint v);
		if (v > SAT_HI) return C_MAX;
		if (v < SAT_LO) return C_MIN;
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [63:0] mag(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [CODE_W-1:0] outcode(longint x, longint y);
		logic [CODE_W-1:0] c;
		c = '0;
		c[BIT_TOP]    = y > win_top;
		c[BIT_BOTTOM] = y < win_bottom;
		c[BIT_RIGHT]  = x > win_right;
		c[BIT_LEFT]   = x < win_left;
		return c;
	endfunction

	// base + trunc(span * num / den), quotient clamped at 2^40, then saturated
	function automatic longint edge_cross(longint base, longint span, longint num,
			longint den);
		logic [127:0] prod;
		logic [127:0] quo;
		longint       q;
		logic         neg;
		if (den == 0) return base;
		neg  = (span < 0) ^ (num < 0) ^ (den < 0);
		prod = 128'(mag(span)) * 128'(mag(num));
		quo  = prod / 128'(mag(den));
		q    = (quo >= (128'd1 << QCLAMP)) ? (longint'(1) << QCLAMP) : longint'(quo[63:0]);
		return longint'(sat32(neg ? base - q : base + q));
	endfunction

	// Run the clip loop and return 1 when the segment is rejected
	function automatic logic predict_rejection(segment_t seg);
		longint            ax, ay, bx, by, nx, ny;
		logic [CODE_W-1:0] ca, cb, co;
		ax = seg.sx;
		ay = seg.sy;
		bx = seg.ex;
		by = seg.ey;
		ca = outcode(ax, ay);
		cb = outcode(bx, by);
		for (int moves = 0; moves <= MAX_PASSES; moves++) begin
			if ((ca | cb) == '0) return 1'b0;
			if ((ca & cb) != '0) return 1'b1;
			if (moves == MAX_PASSES) return 1'b1;
			co = (ca != '0) ? ca : cb;
			if (co[BIT_TOP]) begin
				nx = edge_cross(ax, bx - ax, win_top - ay, by - ay);
				ny = win_top;
			end else if (co[BIT_BOTTOM]) begin
				nx = edge_cross(ax, bx - ax, win_bottom - ay, by - ay);
				ny = win_bottom;
			end else if (co[BIT_RIGHT]) begin
				ny = edge_cross(ay, by - ay, win_right - ax, bx - ax);
				nx = win_right;
			end else begin
				ny = edge_cross(ay, by - ay, win_left - ax, bx - ax);
				nx = win_left;
			end
			if (ca != '0) begin
				ax = nx;
				ay = ny;
				ca = outcode(ax, ay);
			end else begin
				bx = nx;
				by = ny;
				cb = outcode(bx, by);
			end
		end
		return 1'b1;
	endfunction

	// Pick a coordinate, mostly around the window span [lo, hi]
	function automatic logic signed [COORD_W-1:0] pick_coord(longint lo, longint hi);
		longint a, b, w;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		w = b - a + 1;
		case ($urandom_range(9))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(3))
					0: return sat32(a);
					1: return sat32(b);
					2: return sat32(a - 1);
					default: return sat32(b + 1);
				endcase
			end
			3: return $urandom_range(1) ? C_MAX : C_MIN;
			default: return sat32(a - 2 * w + longint'({$urandom, $urandom} % 64'(5 * w)));
		endcase
	endfunction

	task automatic queue_segment(logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
			logic signed [COORD_W-1:0] ex, logic signed [COORD_W-1:0] ey);
		pending_segments.push_back({sx, sy, ex, ey});
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic write_window(logic [1:0] idx, logic [COORD_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_LEFT:   win_left   = longint'(signed'(value));
			REG_RIGHT:  win_right  = longint'(signed'(value));
			REG_BOTTOM: win_bottom = longint'(signed'(value));
			default:    win_top    = longint'(signed'(value));
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_window(logic [COORD_W-1:0] l, logic [COORD_W-1:0] r,
			logic [COORD_W-1:0] b, logic [COORD_W-1:0] t);
		write_window(REG_LEFT, l);
		write_window(REG_RIGHT, r);
		write_window(REG_BOTTOM, b);
		write_window(REG_TOP, t);
	endtask

	// Hold until every queued item is issued and every verdict has come back
	task automatic wait_drained();
		while (pending_segments.size() != 0 || start || expected_rejections.size() != 0)
			@(posedge clk);
	endtask

	// Driver: record the verdict of each accepted item, then offer the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start   <= 1'b0;
			start_x <= '0;
			start_y <= '0;
			end_x   <= '0;
			end_y   <= '0;
		end else begin
			if (start && !busy) begin
				expected_rejections.push_back(predict_rejection({start_x, start_y, end_x, end_y}));
				items_accepted++;
			end
			if (!start || !busy) begin
				if (pending_segments.size() != 0 && $urandom_range(99) >= idle_pct) begin
					next_seg = pending_segments.pop_front();
					start    <= 1'b1;
					start_x  <= next_seg.sx;
					start_y  <= next_seg.sy;
					end_x    <= next_seg.ex;
					end_y    <= next_seg.ey;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each done strobe with the oldest predicted verdict
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rejections.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected verdict rejected=%b", $realtime, rejected);
				mismatches++;
			end else begin
				if (rejected !== expected_rejections[0]) begin
					if (mismatches < 10)
						$display("%0t: verdict %0d: expected rejected=%b, got %b",
							$realtime, verdicts_checked, expected_rejections[0], rejected);
					mismatches++;
				end
				rejects_seen += expected_rejections[0];
				verdicts_checked++;
				void'(expected_rejections.pop_front());
			end
		end
	end

	// Stimulus sequence
	initial begin
		logic signed [COORD_W-1:0] ax, ay;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < PHASES; phase++) begin
			// Change the window only with the block idle
			wait_drained();
			case (phase)
				1: set_window(C_MIN, C_MAX, C_MIN, C_MAX);
				2: set_window(0, 0, 0, 0);
				3: set_window(Q, -Q, 2 * Q, -2 * Q);
				4: set_window($urandom, $urandom, $urandom, $urandom);
				5: set_window(-(21 * Q / 4), 300 * Q, -66, 131);
				6: set_window(WIN_MINUS_ONE, WIN_ONE, WIN_MINUS_ONE, WIN_ONE);
				default: ;
			endcase
			case (phase % 4)
				1: idle_pct = 77;
				3: idle_pct = 26;
				default: idle_pct = 0;
			endcase

			// Directed segments against the reset window
			if (phase == 0) begin
				queue_segment(0, 0, 0, 0);
				queue_segment(C_MIN, C_MIN, C_MAX, C_MAX);
				queue_segment(C_MAX, C_MAX, C_MAX, C_MAX);
				queue_segment(C_MIN, C_MIN, C_MIN, C_MIN);
				queue_segment(C_MIN, 0, C_MAX, 0);
				queue_segment(0, C_MIN, 0, C_MAX);
				queue_segment(C_MAX, C_MIN, C_MIN, C_MAX);
				queue_segment(C_MIN, C_MAX, 0, 0);
				queue_segment(-2 * Q, 3 * Q, 3 * Q, -2 * Q);
				queue_segment(-2 * Q, Q / 2, -Q / 2, 2 * Q);
				queue_segment(Q, Q, -Q, -Q);
				queue_segment(Q + 1, 0, Q + 1, 5 * Q);
				queue_segment(-Q - 1, -Q - 1, -Q - 1, Q + 1);
				queue_segment(0, 0, 5 * Q, 3 * Q / 10);
				queue_segment(5 * Q, 3 * Q / 10, 0, 0);
				queue_segment(Q / 2, 10 * Q, -Q / 2, -10 * Q);
				queue_segment(-3 * Q, -Q / 4, 7 * Q, Q / 3);
				queue_segment(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555);
			end
			// Inverted window: trivial reject and the pass limit
			if (phase == 3) begin
				queue_segment(0, 0, 0, 0);
				queue_segment(5 * Q, 5 * Q, -5 * Q, -5 * Q);
				queue_segment(5 * Q, -5 * Q, -5 * Q, 5 * Q);
			end

			// Random segments, most of them near the window
			for (int n = 0; n < PER_PHASE; n++) begin
				ax = pick_coord(win_left, win_right);
				ay = pick_coord(win_bottom, win_top);
				if ($urandom_range(19) == 0)
					queue_segment(ax, ay, ax, ay);
				else
					queue_segment(ax, ay, pick_coord(win_left, win_right),
						pick_coord(win_bottom, win_top));
			end
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Checked %0d verdicts over %0d accepted segments (%0d rejected, %0d visible),",
			verdicts_checked, items_accepted, rejects_seen, verdicts_checked - rejects_seen);
		$display("across %0d window settings with sender idle levels 0, 26 and 77 percent.",
			PHASES);
		if (mismatches == 0 && expected_rejections.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
